>>> rtl/mna_pkg.sv
// Package for the magazine node allocator: field widths, reset constants,
// result and source codes, controller state type and the command bundle.
// No dependencies.
package mna_pkg;

    localparam int NODE_COUNT_DEF   = 4096;
    localparam int THREAD_COUNT_DEF = 8;

    localparam int ACTION_W = 1;
    localparam int THREAD_W = 3;
    localparam int NODE_W   = 12;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int OOM_W    = 32;

    localparam logic [COUNT_W-1:0] MAGAZINE_RESET = 11'd100;

    // request kinds on s_tuser
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        RES_GRANTED = 2'd0,
        RES_FREED   = 2'd1,
        RES_OOM     = 2'd2
    } status_t;

    // where an allocate takes its node from
    typedef enum logic [1:0] {
        SRC_PRIMARY   = 2'd0,
        SRC_SECONDARY = 2'd1,
        SRC_GLOBAL    = 2'd2,
        SRC_NONE      = 2'd3
    } src_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;   // input transfer: latch request, start link reads
        logic execute;   // link data ready: update state, load result
    } mna_cmd_t;

endpackage

>>> rtl/mna_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mna_ctrl.sv
// Controller for the magazine node allocator: two-state sequencer and
// result valid flag. Depends on mna_pkg.
module mna_ctrl
    import mna_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output mna_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // result slot free, or freed by a transfer at this edge
                if (!out_valid_reg || m_tready)
                begin
                    cmd.execute = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> rtl/mna_datapath.sv
// Datapath for the magazine node allocator: per-thread heads and counts,
// global stack top, link RAMs, size register and result registers.
// Depends on mna_pkg and mna_ram.
module mna_datapath
    import mna_pkg::*;
#(
    parameter int NODE_COUNT   = NODE_COUNT_DEF,
    parameter int THREAD_COUNT = THREAD_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mna_cmd_t            cmd,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    input  logic                in_action,
    input  logic [THREAD_W-1:0] in_thread,
    input  logic [NODE_W-1:0]   in_node,
    output status_t             res_status,
    output logic [NODE_W-1:0]   res_granted,
    output logic [OOM_W-1:0]    res_oom
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int TW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;

    // link = {valid, index}
    typedef logic [NW:0] link_t;

    function automatic logic [TW-1:0] thread_wrap(logic [THREAD_W-1:0] th);
        logic [8:0] v;
        v = 9'(th);
        for (int i = 0; i < (1 << THREAD_W); i++)
        begin
            if (v >= 9'(THREAD_COUNT))
            begin
                v = v - 9'(THREAD_COUNT);
            end
        end
        return TW'(v);
    endfunction

    // thread state
    link_t              primary_head_reg   [THREAD_COUNT];
    link_t              secondary_head_reg [THREAD_COUNT];
    logic [COUNT_W-1:0] primary_count_reg  [THREAD_COUNT];
    link_t              global_top_reg;
    logic [OOM_W-1:0]   oom_reg;
    logic [COUNT_W-1:0] magazine_size_reg;

    // latched request
    logic               action_reg;
    logic [TW-1:0]      thread_reg;
    logic [NODE_W-1:0]  node_reg;
    src_t               src_reg;
    logic [NW-1:0]      addr_reg;

    status_t            status_reg;
    logic [NODE_W-1:0]  granted_reg;

    // capture-side decode
    logic [TW-1:0]      t_in;
    link_t              ph_in;
    link_t              sh_in;
    src_t               src_in;
    logic [NW-1:0]      addr_in;

    // execute-side next values
    link_t              ph_next;
    link_t              sh_next;
    logic [COUNT_W-1:0] cnt_next;
    link_t              gt_next;
    logic [OOM_W-1:0]   oom_next;
    status_t            status_next;
    logic [NODE_W-1:0]  granted_next;

    link_t              ph_cur;
    link_t              sh_cur;
    logic [COUNT_W-1:0] cnt_cur;
    logic [COUNT_W:0]   cnt_inc;
    logic [COUNT_W-1:0] cnt_base;
    logic               node_ok;

    // link RAM ports
    logic               chain_we;
    logic [NW-1:0]      chain_waddr;
    link_t              chain_wdata;
    link_t              chain_rdata;
    logic               stack_we;
    logic [NW-1:0]      stack_waddr;
    link_t              stack_wdata;
    link_t              stack_rdata;
    logic               link_re;

    mna_ram #(
        .WIDTH (NW + 1),
        .DEPTH (NODE_COUNT)
    ) u_chain_ram (
        .clk   (clk),
        .we    (chain_we),
        .waddr (chain_waddr),
        .wdata (chain_wdata),
        .re    (link_re),
        .raddr (addr_in),
        .rdata (chain_rdata)
    );

    mna_ram #(
        .WIDTH (NW + 1),
        .DEPTH (NODE_COUNT)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (link_re),
        .raddr (addr_in),
        .rdata (stack_rdata)
    );

    // pick the allocate source at capture so the link read starts then
    always_comb
    begin
        t_in  = thread_wrap(in_thread);
        ph_in = primary_head_reg[t_in];
        sh_in = secondary_head_reg[t_in];
        if (ph_in[NW])
        begin
            src_in  = SRC_PRIMARY;
            addr_in = ph_in[NW-1:0];
        end
        else if (sh_in[NW])
        begin
            src_in  = SRC_SECONDARY;
            addr_in = sh_in[NW-1:0];
        end
        else if (global_top_reg[NW])
        begin
            src_in  = SRC_GLOBAL;
            addr_in = global_top_reg[NW-1:0];
        end
        else
        begin
            src_in  = SRC_NONE;
            addr_in = '0;
        end
        link_re = cmd.capture && (in_action == ACT_ALLOC);
    end

    always_comb
    begin
        ph_cur  = primary_head_reg[thread_reg];
        sh_cur  = secondary_head_reg[thread_reg];
        cnt_cur = primary_count_reg[thread_reg];
        cnt_inc = {1'b0, cnt_cur} + 12'd1;
        node_ok = 32'(node_reg) < NODE_COUNT;

        ph_next      = ph_cur;
        sh_next      = sh_cur;
        cnt_next     = cnt_cur;
        gt_next      = global_top_reg;
        oom_next     = oom_reg;
        status_next  = RES_FREED;
        granted_next = '0;
        cnt_base     = cnt_cur;

        chain_we    = 1'b0;
        chain_waddr = NW'(node_reg);
        chain_wdata = ph_cur;
        stack_we    = 1'b0;
        stack_waddr = sh_cur[NW-1:0];
        stack_wdata = global_top_reg;

        if (action_reg == ACT_FREE)
        begin
            if (node_ok)
            begin
                chain_we = cmd.execute;
                if (cnt_inc > {1'b0, magazine_size_reg})
                begin
                    // retire the full primary list
                    if (sh_cur[NW])
                    begin
                        stack_we = cmd.execute;
                        gt_next  = sh_cur;
                    end
                    sh_next     = ph_cur;
                    chain_wdata = '0;
                    cnt_next    = COUNT_W'(1);
                end
                else
                begin
                    cnt_next = cnt_inc[COUNT_W-1:0];
                end
                ph_next = {1'b1, NW'(node_reg)};
            end
        end
        else if (src_reg == SRC_NONE)
        begin
            status_next = RES_OOM;
            if (oom_reg != '1)
            begin
                oom_next = oom_reg + 32'd1;
            end
        end
        else
        begin
            status_next  = RES_GRANTED;
            granted_next = NODE_W'(addr_reg);
            ph_next      = chain_rdata;
            if (src_reg == SRC_SECONDARY)
            begin
                sh_next = '0;
            end
            if (src_reg == SRC_GLOBAL)
            begin
                gt_next = stack_rdata;
            end
            if (src_reg != SRC_PRIMARY)
            begin
                cnt_base = magazine_size_reg;
            end
            cnt_next = (cnt_base != '0) ? cnt_base - 11'd1 : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREAD_COUNT; i++)
            begin
                primary_head_reg[i]   <= '0;
                secondary_head_reg[i] <= '0;
                primary_count_reg[i]  <= '0;
            end
            global_top_reg    <= '0;
            oom_reg           <= '0;
            magazine_size_reg <= MAGAZINE_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                magazine_size_reg <= cfg_wdata;
            end
            if (cmd.execute)
            begin
                primary_head_reg[thread_reg]   <= ph_next;
                secondary_head_reg[thread_reg] <= sh_next;
                primary_count_reg[thread_reg]  <= cnt_next;
                global_top_reg                 <= gt_next;
                oom_reg                        <= oom_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= in_action;
            thread_reg <= t_in;
            node_reg   <= in_node;
            src_reg    <= src_in;
            addr_reg   <= addr_in;
        end
        if (cmd.execute)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
        end
    end

    assign res_status  = status_reg;
    assign res_granted = granted_reg;
    // the counter changes only when the next result is loaded
    assign res_oom     = oom_reg;

endmodule

>>> rtl/magazine_node_allocator.sv
// Magazine node allocator, top level: stream ports, configuration port and
// assertions. Depends on mna_pkg, mna_ctrl and mna_datapath.
//
// Per-thread free-node allocator built from magazines. Each request on the
// slave stream is an allocate (s_tuser = 0) or a free (s_tuser = 1) for one
// thread; every request gives exactly one result on the master stream. A
// free pushes the node onto the thread's primary list; once the count would
// pass magazine_size the primary list is retired (old secondary list onto
// the global magazine stack, primary becomes secondary). An allocate pops
// the primary list, refilling from the secondary list and then from the
// global stack; when all are empty it answers out of memory and bumps a
// saturating 32-bit counter. The block works on one request at a time: a
// request first reads the chain and stack link RAMs (read data is
// registered), then updates heads, counts and links and loads the result.
// A waiting result stalls only the update step, and the next request is
// accepted only after the result of the previous one has been loaded.
// Thread indexes wrap modulo THREAD_COUNT; a free of a node at or above
// NODE_COUNT changes nothing and still reports freed. Link RAMs have no
// reset: following a link that was never written is not supported.
// magazine_size (reset 100) may be written only while no request is open.
module magazine_node_allocator
    import mna_pkg::*;
#(
    parameter int NODE_COUNT   = NODE_COUNT_DEF,
    parameter int THREAD_COUNT = THREAD_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // request stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,    // [2:0] thread, [14:3] node, [15] zero
    input  logic [0:0]         s_tuser,    // [0] action
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,    // [11:0] granted_node,
                                           // [43:12] out_of_memory_events, [47:44] zero
    output logic [1:0]         m_tuser,    // [1:0] status
    // configuration: magazine_size
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);

    mna_cmd_t          cmd;
    status_t           res_status;
    logic [NODE_W-1:0] res_granted;
    logic [OOM_W-1:0]  res_oom;

    mna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mna_datapath #(
        .NODE_COUNT   (NODE_COUNT),
        .THREAD_COUNT (THREAD_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_action   (s_tuser[0]),
        .in_thread   (s_tdata[2:0]),
        .in_node     (s_tdata[14:3]),
        .res_status  (res_status),
        .res_granted (res_granted),
        .res_oom     (res_oom)
    );

    assign m_tdata = {4'b0, res_oom, res_granted};
    assign m_tuser = res_status;

    // a request is accepted only in idle, so never two back to back
    a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !s_tready)
        else $error("request accepted while another is open");

    // a finished request always presents its result next cycle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> m_tvalid)
        else $error("result not presented after execute");

    // counter moves only when a result is loaded
    a_oom_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> $stable(m_tdata[43:12]))
        else $error("out-of-memory count changed without a request");

    // only a grant carries a node index
    a_no_stray_node: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != RES_GRANTED) |-> (m_tdata[11:0] == '0))
        else $error("node index on a non-grant result");

endmodule

>>> bench/magazine_node_allocator_tb.sv
// Self-checking bench for magazine_node_allocator: directed table, then random
// phases over several magazine sizes, each result checked against a behavioral
// copy of the free lists. Depends on mna_pkg and the allocator RTL.
`timescale 1ns / 100ps

module magazine_node_allocator_tb
    import mna_pkg::*;
();

    localparam int NODES   = NODE_COUNT_DEF;
    localparam int THREADS = THREAD_COUNT_DEF;

    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 80;
    localparam int IDLE_MAX         = 18;
    localparam int LONG_HOLD_AT     = 160;   // result count at which the sink holds off
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES    = 8;

    // a list head or link: [NODE_W] valid, [NODE_W-1:0] node index
    typedef logic [NODE_W:0] link_t;

    typedef struct packed {
        status_t             status;
        logic [NODE_W-1:0]   node;
        logic [OOM_W-1:0]    oom_events;
    } outcome_t;

    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,   // expected result from the free-list model
        ROW_TYPED   = 2'd1,   // expected result written in the row
        ROW_CFG     = 2'd2    // drain, then write magazine_size
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic                action;
        logic [THREAD_W-1:0] thread;
        logic [NODE_W-1:0]   node;
        logic [COUNT_W-1:0]  size;
        status_t             exp_status;
        logic [NODE_W-1:0]   exp_node;
        logic [OOM_W-1:0]    exp_oom;
    } row_t;

    localparam int DIRECTED_ROWS = 28;

    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        // nothing to hand out after reset; node field is ignored on allocate
        '{ROW_TYPED,   ACT_ALLOC, 3'd0, 12'd0,    11'd0,    RES_OOM,     12'd0,    32'd1},
        '{ROW_TYPED,   ACT_ALLOC, 3'd7, 12'd4095, 11'd0,    RES_OOM,     12'd0,    32'd2},
        '{ROW_TYPED,   ACT_FREE,  3'd7, 12'd4095, 11'd0,    RES_FREED,   12'd0,    32'd2},
        '{ROW_TYPED,   ACT_ALLOC, 3'd7, 12'd0,    11'd0,    RES_GRANTED, 12'd4095, 32'd2},
        '{ROW_TYPED,   ACT_FREE,  3'd0, 12'd0,    11'd0,    RES_FREED,   12'd0,    32'd2},
        // one node per magazine: each further free retires the primary list
        '{ROW_CFG,     ACT_ALLOC, 3'd0, 12'd0,    11'd1,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_FREE,  3'd3, 12'd10,   11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_FREE,  3'd3, 12'd11,   11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_FREE,  3'd3, 12'd12,   11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_FREE,  3'd3, 12'd13,   11'd0,    RES_GRANTED, 12'd0,    32'd0},
        // another thread takes a magazine off the global stack
        '{ROW_PREDICT, ACT_ALLOC, 3'd5, 12'd0,    11'd0,    RES_GRANTED, 12'd0,    32'd0},
        // primary, then secondary, then global stack, then nothing left
        '{ROW_PREDICT, ACT_ALLOC, 3'd3, 12'd0,    11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_ALLOC, 3'd3, 12'd0,    11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_ALLOC, 3'd3, 12'd0,    11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_TYPED,   ACT_ALLOC, 3'd3, 12'd0,    11'd0,    RES_OOM,     12'd0,    32'd3},
        // list longer than the count: pops past zero keep the count at zero
        '{ROW_CFG,     ACT_ALLOC, 3'd0, 12'd0,    11'd3,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_FREE,  3'd1, 12'd20,   11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_FREE,  3'd1, 12'd21,   11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_FREE,  3'd1, 12'd22,   11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_FREE,  3'd1, 12'd23,   11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_CFG,     ACT_ALLOC, 3'd0, 12'd0,    11'd1,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_ALLOC, 3'd1, 12'd0,    11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_ALLOC, 3'd1, 12'd0,    11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_ALLOC, 3'd1, 12'd0,    11'd0,    RES_GRANTED, 12'd0,    32'd0},
        // double free: the node lands on both lists and comes back twice
        '{ROW_PREDICT, ACT_FREE,  3'd2, 12'd5,    11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_FREE,  3'd2, 12'd5,    11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_ALLOC, 3'd2, 12'd0,    11'd0,    RES_GRANTED, 12'd0,    32'd0},
        '{ROW_PREDICT, ACT_ALLOC, 3'd2, 12'd0,    11'd0,    RES_GRANTED, 12'd0,    32'd0}
    };

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata   = '0;    // [2:0] thread, [14:3] node, [15] zero
    logic [0:0]         s_tuser   = '0;    // [0] action
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [47:0]        m_tdata;           // [11:0] granted_node, [43:12] oom events
    logic [1:0]         m_tuser;           // [1:0] status
    logic               cfg_we    = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;

    // free-list state mirrored by the bench
    link_t              chain_next     [NODES];
    link_t              magazine_below [NODES];
    link_t              primary_top    [THREADS];
    link_t              secondary_top  [THREADS];
    logic [COUNT_W-1:0] primary_fill   [THREADS];
    link_t              stack_top;
    logic [OOM_W-1:0]   oom_total;
    logic [COUNT_W-1:0] magazine_limit;

    outcome_t awaited_outcomes [$];

    int errors           = 0;
    int results_seen     = 0;
    int grants_expected  = 0;
    int frees_expected   = 0;
    int ooms_expected    = 0;
    int sender_idle_max  = IDLE_MAX;
    int receiver_idle_max = IDLE_MAX;

    magazine_node_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Apply one request to the mirrored lists and return what the block
    // should answer for it.
    function automatic outcome_t serve_request(input logic act,
                                               input logic [THREAD_W-1:0] t,
                                               input logic [NODE_W-1:0] nd);
        outcome_t          res;
        int unsigned       fill_next;
        logic              have;
        logic [NODE_W-1:0] taken;
        res   = '{RES_FREED, '0, '0};
        have  = 1'b1;
        if (act == ACT_FREE)
        begin
            fill_next = primary_fill[t] + 1;
            if (fill_next > magazine_limit)
            begin
                // retire: old secondary onto the global stack, primary moves down
                if (secondary_top[t][NODE_W])
                begin
                    magazine_below[secondary_top[t][NODE_W-1:0]] = stack_top;
                    stack_top = secondary_top[t];
                end
                secondary_top[t] = primary_top[t];
                primary_top[t]   = '0;
                fill_next        = 1;
            end
            primary_fill[t] = COUNT_W'(fill_next);
            chain_next[nd]  = primary_top[t];
            primary_top[t]  = {1'b1, nd};
        end
        else
        begin
            if (!primary_top[t][NODE_W])
            begin
                if (secondary_top[t][NODE_W])
                begin
                    primary_top[t]   = secondary_top[t];
                    secondary_top[t] = '0;
                end
                else if (stack_top[NODE_W])
                begin
                    primary_top[t] = stack_top;
                    stack_top      = magazine_below[stack_top[NODE_W-1:0]];
                end
                else
                begin
                    have = 1'b0;
                    if (oom_total != '1)
                        oom_total = oom_total + 1'b1;
                end
                if (have)
                    primary_fill[t] = magazine_limit;
            end
            if (have)
            begin
                taken          = primary_top[t][NODE_W-1:0];
                primary_top[t] = chain_next[taken];
                if (primary_fill[t] != '0)
                    primary_fill[t] = primary_fill[t] - 1'b1;
                res.status = RES_GRANTED;
                res.node   = taken;
            end
            else
                res.status = RES_OOM;
        end
        res.oom_events = oom_total;
        return res;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // Offer one request after a random gap; on its transfer, queue the
    // expected result (the row's own value when one is given).
    task automatic offer_request(input logic act, input logic [THREAD_W-1:0] thr,
                                 input logic [NODE_W-1:0] nd, input logic typed,
                                 input outcome_t typed_res);
        int       gap;
        outcome_t res;
        gap = $urandom_range(0, sender_idle_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, nd, thr};
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        res = serve_request(act, thr, nd);
        if (typed)
            res = typed_res;
        awaited_outcomes.push_back(res);
        case (res.status)
            RES_GRANTED: grants_expected++;
            RES_FREED:   frees_expected++;
            default:     ooms_expected++;
        endcase
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge clk);
    endtask

    // Only called with nothing in flight.
    task automatic write_magazine_size(input logic [COUNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        magazine_limit = value;
    endtask

    // Result side: random back-pressure, one long hold-off, in-order check.
    initial
    begin : result_sink
        int       gap;
        outcome_t want;
        @(posedge rst_n);
        forever
        begin
            if (results_seen == LONG_HOLD_AT)
                gap = LONG_HOLD_CYCLES;
            else
                gap = $urandom_range(0, receiver_idle_max);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            results_seen++;
            if (awaited_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t ns: result with none expected: status %0d node %0d oom %0d",
                         $time, m_tuser, m_tdata[11:0], m_tdata[43:12]);
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("granted_node", 32'(want.node), 32'(m_tdata[11:0]));
                check_field("out_of_memory_events", want.oom_events, m_tdata[43:12]);
            end
        end
    end

    initial
    begin : stimulus
        logic                act;
        logic [THREAD_W-1:0] thr;
        logic [THREAD_W-1:0] hot_thread;
        logic [NODE_W-1:0]   nd;
        logic [COUNT_W-1:0]  size;
        int                  alloc_pct;
        for (int i = 0; i < NODES; i++)
        begin
            chain_next[i]     = '0;
            magazine_below[i] = '0;
        end
        for (int i = 0; i < THREADS; i++)
        begin
            primary_top[i]   = '0;
            secondary_top[i] = '0;
            primary_fill[i]  = '0;
        end
        stack_top      = '0;
        oom_total      = '0;
        magazine_limit = MAGAZINE_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                wait_until_drained();
                write_magazine_size(DIRECTED[i].size);
            end
            else
                offer_request(DIRECTED[i].action, DIRECTED[i].thread, DIRECTED[i].node,
                              DIRECTED[i].kind == ROW_TYPED,
                              '{DIRECTED[i].exp_status, DIRECTED[i].exp_node,
                                DIRECTED[i].exp_oom});
        end

        // Random phases: drain, pick a size, then traffic leaning on one thread
        // so its lists grow deep enough to retire and refill magazines.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       size = 11'd1024;
                1:       size = 11'd2;
                2:       size = 11'd1;
                3:       size = 11'd7;
                4:       size = COUNT_W'($urandom_range(3, 40));
                default: size = COUNT_W'($urandom_range(1, 1024));
            endcase
            wait_until_drained();
            write_magazine_size(size);
            alloc_pct         = (ph % 2 == 1) ? 60 : 40;
            sender_idle_max   = (ph % 3 == 1) ? 0 : IDLE_MAX;
            receiver_idle_max = (ph % 3 == 2) ? 0 : IDLE_MAX;
            hot_thread        = THREAD_W'($urandom_range(0, THREADS - 1));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                act = ($urandom_range(0, 99) < alloc_pct) ? ACT_ALLOC : ACT_FREE;
                if ($urandom_range(0, 9) < 6)
                    thr = hot_thread;
                else
                    thr = THREAD_W'($urandom_range(0, THREADS - 1));
                case ($urandom_range(0, 9))
                    0:       nd = '0;
                    1:       nd = '1;
                    default: nd = NODE_W'($urandom_range(0, NODES - 1));
                endcase
                offer_request(act, thr, nd, 1'b0, '0);
            end
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d requests: %0d grants, %0d frees, %0d out-of-memory answers,",
                 grants_expected + frees_expected + ooms_expected, grants_expected,
                 frees_expected, ooms_expected);
        $display("over %0d magazine size writes from 1 to 1024 with stalls on both streams.",
                 RANDOM_PHASES + 3);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
